@@ hw/rtl/i2c_master_transfer_engine_defines.svh @@
// Assertion macros used by the checker file of the I2C master transfer engine.
`ifndef I2C_MASTER_TRANSFER_ENGINE_DEFINES_SVH
`define I2C_MASTER_TRANSFER_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define I2CM_CHK_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("i2cm check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define I2CM_CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("i2cm check failed");

`endif

@@ hw/rtl/i2cm_pkg.sv @@
// Types, codes and helper functions of the I2C master transfer engine.
package i2cm_pkg;

	localparam logic [15:0] BIT_DELAY_RST = 16'd10;
	localparam int unsigned TDATA_IN_W = 40;
	localparam int unsigned TDATA_OUT_W = 16;

	// register indexes (paddr bit 2)
	localparam logic REG_BIT_DELAY = 1'b0;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_ADDR  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		LINK_IDLE = 2'd0,
		LINK_ACK  = 2'd1,
		LINK_NAK  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_START_LO = 4'd1,
		PH_REP_HI   = 4'd2,
		PH_REP_LO   = 4'd3,
		PH_PUT_HI   = 4'd4,
		PH_PUT_LO   = 4'd5,
		PH_PACK_HI  = 4'd6,
		PH_PACK_LO  = 4'd7,
		PH_GET_PRE  = 4'd8,
		PH_GET_HI   = 4'd9,
		PH_GET_LO   = 4'd10,
		PH_GACK_HI  = 4'd11,
		PH_GACK_LO  = 4'd12,
		PH_STOP_HI  = 4'd13
	} phase_t;

	typedef enum logic [1:0] {
		ES_HALF    = 2'd0,
		ES_STRETCH = 2'd1,
		ES_FULL    = 2'd2
	} estep_t;

	typedef struct packed {
		mode_t       mode;
		logic        begin_flag;
		logic        end_flag;
		logic [6:0]  target_address;
		logic        read_dir;
		logic [15:0] byte_count;
		logic [7:0]  write_byte;
		logic        scl_sense;
		logic        sda_sense;
	} item_t;

	typedef struct packed {
		logic        scl_pull_low;
		logic        sda_pull_low;
		logic        busy_res;
		logic        done_res;
		logic        acked;
		logic [7:0]  read_byte;
		status_t     link_status;
		logic        more_data;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		estep_t      estep;
		logic [2:0]  bit_idx;
		logic [7:0]  shift;
		logic [15:0] wait_cnt;
		logic [15:0] bytes_left;
		logic        stop_at_end;
		status_t     status;
		logic        scl_low;
		logic        sda_low;
		mode_t       active;
		logic        ack_seen;
		logic        more;
	} state_t;

	// phases that end with a rising SCL edge
	function automatic logic phase_rising(phase_t p);
		return p inside {PH_REP_HI, PH_PUT_HI, PH_PACK_HI, PH_GET_HI, PH_GACK_HI,
			PH_STOP_HI};
	endfunction

	// start a new SCL edge: half wait first
	function automatic state_t edge_to(state_t s, phase_t p, logic [15:0] half);
		state_t r;
		r = s;
		r.phase = p;
		r.estep = ES_HALF;
		r.wait_cnt = half;
		return r;
	endfunction

endpackage

@@ hw/rtl/i2cm_cfg.sv @@
// APB register file of the I2C master transfer engine: the bit delay register.
module i2cm_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] bit_delay
);
	import i2cm_pkg::*;

	logic [15:0] bit_delay_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && (paddr[2] == REG_BIT_DELAY);

	// store the delay, clamp zero to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_delay_q <= BIT_DELAY_RST;
		end else if (wr_en) begin
			bit_delay_q <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
		end
	end

	// read back
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_BIT_DELAY) begin
			prdata = {16'd0, bit_delay_q};
		end
	end

	assign bit_delay = bit_delay_q;
endmodule

@@ hw/rtl/i2cm_step.sv @@
// Next-state and result logic of the I2C master for one tick.
module i2cm_step (
	input  i2cm_pkg::state_t  st,
	input  i2cm_pkg::item_t   item,
	input  logic [15:0]       bit_delay,
	output i2cm_pkg::state_t  st_nxt,
	output i2cm_pkg::result_t res
);
	import i2cm_pkg::*;

	logic [15:0] half;
	logic        is_idle;
	logic        fin;
	logic        refused;
	state_t      n;

	// half delay, at least one tick
	assign half = (bit_delay[15:1] == 15'd0) ? 16'd1 : {1'b0, bit_delay[15:1]};
	assign is_idle = (st.phase == PH_IDLE) || (st.phase > PH_STOP_HI);

	// advance the sequencer by one tick
	always_comb begin
		n = st;
		fin = 1'b0;
		refused = 1'b0;
		if (is_idle) begin
			n.phase = PH_IDLE;
			case (item.mode)
				MODE_ADDR: begin
					n.active = MODE_ADDR;
					n.ack_seen = 1'b0;
					n.more = |item.byte_count;
					n.bytes_left = item.byte_count;
					n.stop_at_end = item.end_flag;
					n.shift = {item.target_address, item.read_dir};
					if (item.begin_flag) begin
						n.sda_low = 1'b1;
						n = edge_to(n, PH_START_LO, half);
					end else begin
						n.sda_low = 1'b0;
						n = edge_to(n, PH_REP_HI, half);
					end
				end
				MODE_WRITE, MODE_READ: begin
					if (st.status != LINK_ACK || st.bytes_left == 16'd0) begin
						refused = 1'b1;
					end else begin
						n.active = item.mode;
						n.ack_seen = 1'b0;
						n.bytes_left = st.bytes_left - 16'd1;
						n.bit_idx = 3'd7;
						if (item.mode == MODE_WRITE) begin
							n.shift = item.write_byte;
							n.sda_low = !n.shift[3'd7];
							n = edge_to(n, PH_PUT_HI, half);
						end else begin
							n.shift = 8'd0;
							n.sda_low = 1'b0;
							n = edge_to(n, PH_GET_PRE, half);
						end
					end
				end
				default: begin
				end
			endcase
		end else begin
			case (st.estep)
				ES_HALF: begin
					if (st.wait_cnt > 16'd1) begin
						n.wait_cnt = st.wait_cnt - 16'd1;
					end else if (phase_rising(st.phase)) begin
						n.wait_cnt = 16'd0;
						n.scl_low = 1'b0;
						n.estep = ES_STRETCH;
					end else begin
						n.scl_low = 1'b1;
						n.estep = ES_FULL;
						n.wait_cnt = bit_delay;
					end
				end
				ES_STRETCH: begin
					if (item.scl_sense) begin
						n.estep = ES_FULL;
						n.wait_cnt = bit_delay;
					end
				end
				default: begin
					if (st.wait_cnt > 16'd1) begin
						n.wait_cnt = st.wait_cnt - 16'd1;
					end else begin
						n.wait_cnt = 16'd0;
						// edge finished: pick the next one
						case (st.phase)
							PH_START_LO, PH_REP_LO: begin
								n.bit_idx = 3'd7;
								n.sda_low = !n.shift[3'd7];
								n = edge_to(n, PH_PUT_HI, half);
							end
							PH_REP_HI: begin
								n.sda_low = 1'b1;
								n = edge_to(n, PH_REP_LO, half);
							end
							PH_PUT_HI: n = edge_to(n, PH_PUT_LO, half);
							PH_PUT_LO: begin
								if (st.bit_idx != 3'd0) begin
									n.bit_idx = st.bit_idx - 3'd1;
									n.sda_low = !n.shift[n.bit_idx];
									n = edge_to(n, PH_PUT_HI, half);
								end else begin
									n.sda_low = 1'b0;
									n = edge_to(n, PH_PACK_HI, half);
								end
							end
							PH_PACK_HI: begin
								n.ack_seen = !item.sda_sense;
								n = edge_to(n, PH_PACK_LO, half);
							end
							PH_PACK_LO: begin
								if (st.active == MODE_ADDR && !st.ack_seen) begin
									n.status = LINK_NAK;
									n.bytes_left = 16'd0;
									n.sda_low = 1'b1;
									n = edge_to(n, PH_STOP_HI, half);
								end else begin
									if (st.active == MODE_ADDR) begin
										n.status = LINK_ACK;
									end
									if (n.stop_at_end && n.bytes_left == 16'd0) begin
										n.sda_low = 1'b1;
										n = edge_to(n, PH_STOP_HI, half);
									end else begin
										n.phase = PH_IDLE;
										n.estep = ES_HALF;
										fin = 1'b1;
									end
								end
							end
							PH_GET_PRE: n = edge_to(n, PH_GET_HI, half);
							PH_GET_HI: begin
								n.shift = {st.shift[6:0], item.sda_sense};
								n = edge_to(n, PH_GET_LO, half);
							end
							PH_GET_LO: begin
								if (st.bit_idx != 3'd0) begin
									n.bit_idx = st.bit_idx - 3'd1;
									n = edge_to(n, PH_GET_HI, half);
								end else begin
									n.sda_low = (st.bytes_left != 16'd0);
									n = edge_to(n, PH_GACK_HI, half);
								end
							end
							PH_GACK_HI: n = edge_to(n, PH_GACK_LO, half);
							PH_GACK_LO: begin
								if (st.stop_at_end && st.bytes_left == 16'd0) begin
									n.sda_low = 1'b1;
									n = edge_to(n, PH_STOP_HI, half);
								end else begin
									n.sda_low = 1'b0;
									n.phase = PH_IDLE;
									n.estep = ES_HALF;
									fin = 1'b1;
								end
							end
							PH_STOP_HI: begin
								n.sda_low = 1'b0;
								n.phase = PH_IDLE;
								n.estep = ES_HALF;
								fin = 1'b1;
							end
							default: begin
								n.phase = PH_IDLE;
								n.estep = ES_HALF;
								fin = 1'b1;
							end
						endcase
					end
				end
			endcase
		end
	end

	// build the result of this tick
	always_comb begin
		res = '0;
		res.scl_pull_low = n.scl_low;
		res.sda_pull_low = n.sda_low;
		res.busy_res = (n.phase != PH_IDLE);
		res.done_res = fin || refused;
		res.link_status = n.status;
		if (fin) begin
			case (n.active)
				MODE_ADDR: begin
					res.acked = n.ack_seen;
					res.more_data = n.more;
				end
				MODE_WRITE: res.acked = n.ack_seen;
				default: res.read_byte = n.shift;
			endcase
		end
	end

	assign st_nxt = n;
endmodule

@@ hw/rtl/i2c_master_transfer_engine.sv @@
// Top level of the I2C master transfer engine: stream stages, state and registers.
//
//  channel   | role        | payload
//  ----------+-------------+---------------------------------------------
//  s_axis    | tick in     | tuser mode, tdata command fields and pin levels
//  m_axis    | result out  | tdata line drives, busy/done, ack, read byte, status
//  apb       | config      | bit_delay at byte address 0
//
// One tick is taken per clock cycle while the result register is free or being taken;
// each result passes through the input register and then the result register.
// A stalled result holds m_tdata; one more tick waits in the input register, then
// s_tready drops. arst_n clears the sequencer state and sets bit_delay to 10.
module i2c_master_transfer_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [1:0]                        s_tuser,   // mode
	input  logic [i2cm_pkg::TDATA_IN_W-1:0]   s_tdata,   // begin_flag, end_flag,
	                                                     // target_address[6:0], read_dir,
	                                                     // byte_count[15:0], write_byte[7:0],
	                                                     // scl_sense, sda_sense, zero pad[3:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [i2cm_pkg::TDATA_OUT_W-1:0]  m_tdata,   // scl_pull_low, sda_pull_low,
	                                                     // busy_res, done_res, acked,
	                                                     // read_byte[7:0], link_status[1:0],
	                                                     // more_data
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import i2cm_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        adv;
	state_t      state_q;
	state_t      state_nxt;
	result_t     res;
	logic [15:0] bit_delay;

	i2cm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.bit_delay(bit_delay)
	);

	i2cm_step u_step (
		.st       (state_q),
		.item     (item_s1),
		.bit_delay(bit_delay),
		.st_nxt   (state_nxt),
		.res      (res)
	);

	// advance the input stage when the result register is free or being taken
	assign adv = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// capture the tick on transfer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode           <= mode_t'(s_tuser);
			item_s1.begin_flag     <= s_tdata[0];
			item_s1.end_flag       <= s_tdata[1];
			item_s1.target_address <= s_tdata[8:2];
			item_s1.read_dir       <= s_tdata[9];
			item_s1.byte_count     <= s_tdata[25:10];
			item_s1.write_byte     <= s_tdata[33:26];
			item_s1.scl_sense      <= s_tdata[34];
			item_s1.sda_sense      <= s_tdata[35];
		end
	end

	// sequencer state, updated once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, estep: ES_HALF, active: MODE_NONE,
				status: LINK_IDLE, default: '0};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {res.more_data, res.link_status, res.read_byte, res.acked,
				res.done_res, res.busy_res, res.sda_pull_low, res.scl_pull_low};
		end
	end
endmodule

@@ hw/rtl/i2cm_checker.sv @@
// Port-level checker of the I2C master transfer engine and its bind.
`include "i2c_master_transfer_engine_defines.svh"

module i2cm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        pready
);
	import i2cm_pkg::*;

	// a stalled result holds
	`I2CM_CHK_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// a finishing tick never reports busy
	`I2CM_CHK_NOW(a_done_idle, m_tvalid && m_tdata[3], !m_tdata[2])
	// ack, read byte and more-data stay zero outside a finishing tick
	`I2CM_CHK_NOW(a_quiet, m_tvalid && !m_tdata[3], m_tdata[15] == 1'b0 && m_tdata[12:4] == 9'd0)
	// link status only idle, ack or nak; pready stays high
	`I2CM_CHK_NOW(a_status, m_tvalid, m_tdata[14:13] != 2'b11 && pready)
endmodule

bind i2c_master_transfer_engine i2cm_checker u_i2cm_checker (.*);

@@ verif/tb.sv @@
// Testbench for the I2C master transfer engine: tick stream checked against a bit-level predictor.
`timescale 1ns / 100ps

module tb;
	import i2cm_pkg::*;

	localparam logic [2:0] BIT_DELAY_ADDR = {REG_BIT_DELAY, 2'b00};
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic [7:0] STALL_PATTERN = 8'b0011_1101;
	localparam int unsigned TICK_BUDGET = 1850;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = MODE_NONE;   // mode
	logic [39:0] s_tdata = '0;          // begin_flag, end_flag, target_address[6:0], read_dir,
	                                    // byte_count[15:0], write_byte[7:0], scl_sense,
	                                    // sda_sense, zero pad[3:0]
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [15:0] m_tdata;               // scl_pull_low, sda_pull_low, busy_res, done_res, acked,
	                                    // read_byte[7:0], link_status[1:0], more_data
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	i2c_master_transfer_engine uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted engine state
	logic [15:0] delay_ticks = BIT_DELAY_RST;
	phase_t      ph = PH_IDLE;
	estep_t      wait_stage = ES_HALF;
	logic [2:0]  bit_no = '0;
	logic [7:0]  shifter = '0;
	logic [15:0] wait_left = '0;
	logic [15:0] bytes_owed = '0;
	logic        stop_armed = 1'b0;
	status_t     link = LINK_IDLE;
	logic        scl_low = 1'b0;
	logic        sda_low = 1'b0;
	mode_t       running = MODE_NONE;
	logic        got_ack = 1'b0;
	logic        had_data = 1'b0;
	logic        cmd_finished = 1'b0;

	// bookkeeping
	result_t     pending_results[$];
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned ticks_sent = 0;
	int unsigned commands_closed = 0;
	int unsigned refused_addrs = 0;
	int unsigned burst_left = 0;
	logic        valid_up = 1'b0;
	int unsigned ack_odds = 80;       // percent of ticks that sense SDA low
	int unsigned stretch_odds = 0;    // percent of ticks that sense SCL held low

	// start an SCL edge: half delay first
	function automatic void arm_edge(phase_t p);
		ph = p;
		wait_stage = ES_HALF;
		wait_left = ((delay_ticks >> 1) != 0) ? (delay_ticks >> 1) : 16'd1;
	endfunction

	// put the MSB of the shifter on SDA and head for its rising edge
	function automatic void shift_out_first();
		bit_no = 3'd7;
		sda_low = !shifter[7];
		arm_edge(PH_PUT_HI);
	endfunction

	function automatic void drive_stop();
		sda_low = 1'b1;
		arm_edge(PH_STOP_HI);
	endfunction

	function automatic void close_command();
		ph = PH_IDLE;
		wait_stage = ES_HALF;
		cmd_finished = 1'b1;
	endfunction

	// stop once the count is used up and the end flag asks for it
	function automatic void after_byte();
		if (stop_armed && bytes_owed == 0)
			drive_stop();
		else
			close_command();
	endfunction

	// advance the predicted engine by one tick and return the result it gives
	function automatic result_t engine_tick(item_t it);
		result_t r;
		logic    refused;
		refused = 1'b0;
		cmd_finished = 1'b0;
		if (ph == PH_IDLE) begin
			case (it.mode)
				MODE_ADDR: begin
					running = MODE_ADDR;
					got_ack = 1'b0;
					had_data = (it.byte_count != 0);
					bytes_owed = it.byte_count;
					stop_armed = it.end_flag;
					shifter = {it.target_address, it.read_dir};
					if (it.begin_flag) begin
						sda_low = 1'b1;
						arm_edge(PH_START_LO);
					end else begin
						sda_low = 1'b0;
						arm_edge(PH_REP_HI);
					end
				end
				MODE_WRITE, MODE_READ: begin
					if (link != LINK_ACK || bytes_owed == 0) begin
						refused = 1'b1;
					end else begin
						running = it.mode;
						got_ack = 1'b0;
						bytes_owed = bytes_owed - 1'b1;
						if (it.mode == MODE_WRITE) begin
							shifter = it.write_byte;
							shift_out_first();
						end else begin
							shifter = '0;
							bit_no = 3'd7;
							sda_low = 1'b0;
							arm_edge(PH_GET_PRE);
						end
					end
				end
				default: ;
			endcase
		end else if (wait_stage == ES_HALF) begin
			// half delay, then drive the edge
			if (wait_left > 1) begin
				wait_left = wait_left - 1'b1;
			end else begin
				wait_left = '0;
				if (ph == PH_REP_HI || ph == PH_PUT_HI || ph == PH_PACK_HI ||
						ph == PH_GET_HI || ph == PH_GACK_HI || ph == PH_STOP_HI) begin
					scl_low = 1'b0;
					wait_stage = ES_STRETCH;
				end else begin
					scl_low = 1'b1;
					wait_stage = ES_FULL;
					wait_left = delay_ticks;
				end
			end
		end else if (wait_stage == ES_STRETCH) begin
			// hold while the target stretches the clock
			if (it.scl_sense) begin
				wait_stage = ES_FULL;
				wait_left = delay_ticks;
			end
		end else if (wait_left > 1) begin
			wait_left = wait_left - 1'b1;
		end else begin
			// full delay over: act on the edge just completed
			wait_left = '0;
			case (ph)
				PH_START_LO, PH_REP_LO: shift_out_first();
				PH_REP_HI: begin
					sda_low = 1'b1;
					arm_edge(PH_REP_LO);
				end
				PH_PUT_HI: arm_edge(PH_PUT_LO);
				PH_PUT_LO: begin
					if (bit_no != 0) begin
						bit_no = bit_no - 1'b1;
						sda_low = !shifter[bit_no];
						arm_edge(PH_PUT_HI);
					end else begin
						sda_low = 1'b0;
						arm_edge(PH_PACK_HI);
					end
				end
				PH_PACK_HI: begin
					got_ack = !it.sda_sense;
					arm_edge(PH_PACK_LO);
				end
				PH_PACK_LO: begin
					if (running == MODE_ADDR && !got_ack) begin
						link = LINK_NAK;
						bytes_owed = '0;
						refused_addrs++;
						drive_stop();
					end else begin
						if (running == MODE_ADDR)
							link = LINK_ACK;
						after_byte();
					end
				end
				PH_GET_PRE: arm_edge(PH_GET_HI);
				PH_GET_HI: begin
					shifter = {shifter[6:0], it.sda_sense};
					arm_edge(PH_GET_LO);
				end
				PH_GET_LO: begin
					if (bit_no != 0) begin
						bit_no = bit_no - 1'b1;
						arm_edge(PH_GET_HI);
					end else begin
						// ACK every byte but the last
						sda_low = (bytes_owed != 0);
						arm_edge(PH_GACK_HI);
					end
				end
				PH_GACK_HI: arm_edge(PH_GACK_LO);
				PH_GACK_LO: begin
					sda_low = 1'b0;
					after_byte();
				end
				PH_STOP_HI: begin
					sda_low = 1'b0;
					close_command();
				end
				default: close_command();
			endcase
		end

		r = '0;
		r.scl_pull_low = scl_low;
		r.sda_pull_low = sda_low;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = cmd_finished || refused;
		r.link_status = link;
		if (cmd_finished) begin
			case (running)
				MODE_ADDR: begin
					r.acked = got_ack;
					r.more_data = had_data;
				end
				MODE_WRITE: r.acked = got_ack;
				default: r.read_byte = shifter;
			endcase
		end
		return r;
	endfunction

	// random tick: pin levels follow the current odds, mode mostly none
	function automatic item_t line_tick();
		item_t it;
		it.mode = ($urandom_range(0, 6) == 0) ? mode_t'($urandom_range(1, 3)) : MODE_NONE;
		it.begin_flag = 1'($urandom_range(0, 1));
		it.end_flag = 1'($urandom_range(0, 1));
		it.target_address = 7'($urandom_range(0, 127));
		it.read_dir = 1'($urandom_range(0, 1));
		it.byte_count = 16'($urandom_range(0, 65535));
		it.write_byte = 8'($urandom_range(0, 255));
		it.scl_sense = ($urandom_range(0, 99) >= stretch_odds);
		it.sda_sense = ($urandom_range(0, 99) >= ack_odds);
		return it;
	endfunction

	function automatic item_t addr_cmd(logic b, logic e, logic [6:0] a, logic rd,
			logic [15:0] count);
		item_t it;
		it = line_tick();
		it.mode = MODE_ADDR;
		it.begin_flag = b;
		it.end_flag = e;
		it.target_address = a;
		it.read_dir = rd;
		it.byte_count = count;
		return it;
	endfunction

	function automatic item_t byte_cmd(mode_t m, logic [7:0] w);
		item_t it;
		it = line_tick();
		it.mode = m;
		it.write_byte = w;
		return it;
	endfunction

	// send one tick, predict its result, then idle between bursts
	task automatic send_tick(input item_t it);
		result_t want;
		s_tvalid <= 1'b1;
		valid_up = 1'b1;
		s_tuser <= it.mode;
		s_tdata <= {4'b0, it.sda_sense, it.scl_sense, it.write_byte, it.byte_count,
			it.read_dir, it.target_address, it.end_flag, it.begin_flag};
		do @(posedge clk); while (!s_tready);
		want = engine_tick(it);
		pending_results.push_back(want);
		ticks_sent++;
		if (want.done_res)
			commands_closed++;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			valid_up = 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(0, 12);
		end
	endtask

	// issue a command and keep ticking until the engine is idle again
	task automatic do_cmd(input item_t it);
		send_tick(it);
		while (ph != PH_IDLE)
			send_tick(line_tick());
	endtask

	task automatic idle_ticks(input int unsigned n);
		item_t it;
		repeat (n) begin
			it = line_tick();
			it.mode = MODE_NONE;
			send_tick(it);
		end
	endtask

	// drop valid and wait for every expected result plus the pipeline depth
	task automatic settle();
		if (valid_up) begin
			s_tvalid <= 1'b0;
			valid_up = 1'b0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one APB transfer; the bus stays selected when another follows at once
	task automatic apb_transfer(input logic wr, input logic [31:0] wdata, input logic drop_bus,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= BIT_DELAY_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (drop_bus) begin
			psel <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic set_bit_delay(input logic [15:0] v);
		logic [31:0] readback;
		settle();
		apb_transfer(1'b1, {16'd0, v}, 1'b0, readback);
		delay_ticks = (v == 0) ? 16'd1 : v;
		apb_transfer(1'b0, '0, 1'b1, readback);
		if (readback !== {16'd0, delay_ticks}) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("bit_delay readback: expected %0d, got %0d", delay_ticks, readback);
		end
	endtask

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin : result_checker
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d arrived with nothing expected: %h",
						results_checked, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== {want.more_data, want.link_status, want.read_byte, want.acked,
						want.done_res, want.busy_res, want.sda_pull_low, want.scl_pull_low}) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("result %0d mismatch", results_checked);
						$display("  expected scl %b sda %b busy %b done %b ack %b byte %h st %0d more %b",
							want.scl_pull_low, want.sda_pull_low, want.busy_res,
							want.done_res, want.acked, want.read_byte, want.link_status,
							want.more_data);
						$display("  got      scl %b sda %b busy %b done %b ack %b byte %h st %0d more %b",
							m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[3],
							m_tdata[4], m_tdata[12:5], m_tdata[14:13], m_tdata[15]);
					end
				end
			end
			results_checked++;
		end
	end

	// receiver stalls: always ready, random, or a fixed pattern, switched now and then
	logic [8:0]  stall_hold = '0;
	int unsigned stall_style = 0;
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_style <= $urandom_range(0, 2);
			stall_hold <= 9'($urandom_range(50, 300));
		end else begin
			stall_hold <= stall_hold - 1'b1;
		end
		case (stall_style)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 99) >= 35);
			default: m_tready <= STALL_PATTERN[stall_hold[2:0]];
		endcase
	end

	// byte commands before any address are refused
	task automatic test_refused_when_idle();
		ack_odds = 80;
		stretch_odds = 0;
		idle_ticks(3);
		do_cmd(byte_cmd(MODE_WRITE, 8'hff));
		do_cmd(byte_cmd(MODE_READ, 8'h00));
	endtask

	// refused address at the reset delay: NAK status, count cleared, stop
	task automatic test_nak_at_reset_delay();
		ack_odds = 0;
		do_cmd(addr_cmd(1'b1, 1'b1, 7'h7f, 1'b0, 16'd5));
		do_cmd(byte_cmd(MODE_WRITE, 8'h3c));
	endtask

	task automatic test_zero_delay_clamp();
		set_bit_delay(16'd0);
	endtask

	// repeated start, written bytes acked and refused, stop after the last, then overrun
	task automatic test_write_transfer();
		ack_odds = 100;
		stretch_odds = 0;
		do_cmd(addr_cmd(1'b0, 1'b1, 7'h5a, 1'b0, 16'd3));
		do_cmd(byte_cmd(MODE_WRITE, 8'hff));
		ack_odds = 0;
		do_cmd(byte_cmd(MODE_WRITE, 8'h00));
		ack_odds = 100;
		stretch_odds = 50;
		do_cmd(byte_cmd(MODE_WRITE, 8'ha5));
		do_cmd(byte_cmd(MODE_WRITE, 8'h5a));
	endtask

	// reads of all zeros and all ones; the last read byte is NAKed and followed by stop, then an overrun read is refused
	task automatic test_read_transfer();
		ack_odds = 100;
		stretch_odds = 30;
		do_cmd(addr_cmd(1'b1, 1'b1, 7'h7f, 1'b1, 16'd2));
		do_cmd(byte_cmd(MODE_READ, 8'h00));
		ack_odds = 0;
		do_cmd(byte_cmd(MODE_READ, 8'hff));
		do_cmd(byte_cmd(MODE_READ, 8'h00));
	endtask

	// zero and full counts, with and without stop, then a refused address clears the count
	task automatic test_address_only();
		ack_odds = 100;
		stretch_odds = 0;
		do_cmd(addr_cmd(1'b1, 1'b1, 7'h00, 1'b0, 16'd0));
		do_cmd(addr_cmd(1'b0, 1'b0, 7'h55, 1'b1, 16'd0));
		do_cmd(addr_cmd(1'b0, 1'b0, 7'h2a, 1'b0, 16'hffff));
		do_cmd(byte_cmd(MODE_WRITE, 8'h81));
		do_cmd(byte_cmd(MODE_READ, 8'h00));
		ack_odds = 0;
		do_cmd(addr_cmd(1'b1, 1'b1, 7'h2a, 1'b1, 16'd7));
		do_cmd(byte_cmd(MODE_WRITE, 8'h42));
	endtask

	// longest delay: only refused byte commands and idle ticks, no bus activity
	task automatic test_longest_delay();
		set_bit_delay(16'hffff);
		repeat (4)
			do_cmd(byte_cmd(mode_t'($urandom_range(2, 3)), 8'($urandom)));
		idle_ticks(10);
	endtask

	// one address phase with random content, then its data bytes and some noise
	task automatic random_transfer();
		logic        rd;
		logic [15:0] count;
		int unsigned nbytes;
		mode_t       m;
		ack_odds = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(60, 100);
		stretch_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
		if ($urandom_range(0, 7) == 0)
			do_cmd(byte_cmd(mode_t'($urandom_range(2, 3)), 8'($urandom)));
		rd = 1'($urandom_range(0, 1));
		count = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		do_cmd(addr_cmd(1'($urandom_range(0, 1)), ($urandom_range(0, 9) < 7), 7'($urandom), rd,
			count));
		nbytes = (count > 3) ? $urandom_range(0, 3) : count + $urandom_range(0, 1);
		repeat (nbytes) begin
			m = rd ? MODE_READ : MODE_WRITE;
			if ($urandom_range(0, 9) == 0)
				m = rd ? MODE_WRITE : MODE_READ;
			do_cmd(byte_cmd(m, 8'($urandom)));
		end
		idle_ticks($urandom_range(0, 3));
	endtask

	// share the remaining tick budget evenly across five delay settings
	task automatic test_random_traffic();
		int unsigned first;
		first = ticks_sent;
		for (int p = 0; p < 5; p++) begin
			set_bit_delay((p == 0) ? 16'd1 : 16'($urandom_range(1, 6)));
			while (ticks_sent < first + (TICK_BUDGET - first) * (p + 1) / 5)
				random_transfer();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_refused_when_idle();
		test_nak_at_reset_delay();
		test_zero_delay_clamp();
		test_write_transfer();
		test_read_transfer();
		test_address_only();
		test_longest_delay();
		test_random_traffic();
		settle();
		$display("Covered %0d ticks and %0d results at bit_delay 10, 1 to 6 and 65535.",
			ticks_sent, results_checked);
		$display("%0d commands finished or refused, %0d addresses refused, %0d mismatches.",
			commands_closed, refused_addrs, mismatches);
		if (mismatches == 0)
			$display("** i2c_master_transfer_engine: PASSED **");
		else
			$display("** i2c_master_transfer_engine: FAILED **");
		$finish;
	end

	// hang guard
	initial begin
		#2_000_000;
		$display("Timed out with %0d results still expected.", pending_results.size());
		$display("** i2c_master_transfer_engine: FAILED **");
		$finish;
	end

endmodule
